// ===== src/sst_pkg.sv =====
`timescale 1ns / 1ps
package sst_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } sst_state_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic ptr_init;
    logic shift_rd;
    logic shift_wr;
    logic write_new;
    logic res_load;
    logic res_success;
    logic res_full;
    logic cnt_inc;
    logic cnt_dec;
  } sst_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       found;
    logic       full;
    logic       search_done;
    logic       shift_done;
  } sst_stat_t;

endpackage

// ===== src/sst_ram.sv =====
`timescale 1ns / 1ps
module sst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sst_dp.sv =====
`timescale 1ns / 1ps
module sst_dp
  import sst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  sst_cmd_t                 cmd,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output sst_stat_t                stat,
  output logic                     out_success,
  output logic                     out_full_res
);

  logic [1:0]               op_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic                     found_r, found_nxt;
  logic                     success_r, full_r;

  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         mid;
  logic [CNT_W-1:0]         ptr_inc, ptr_dec;
  logic                     is_ins;
  logic [DATA_W-1:0]        rdata;
  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         raddr;
  logic [DATA_W-1:0]        wdata;
  logic                     ent_lt, ent_eq;

  assign is_ins  = (op_r == OP_INSERT);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);
  assign ent_lt  = $signed(rdata) < value_r;
  assign ent_eq  = $signed(rdata) == value_r;

  always_comb begin
    if (cmd.srch_rd) begin
      raddr = mid[IDX_W-1:0];
    end else if (is_ins) begin
      raddr = ptr_dec[IDX_W-1:0];
    end else begin
      raddr = ptr_inc[IDX_W-1:0];
    end
  end

  assign ram_re = cmd.srch_rd | cmd.shift_rd;
  assign ram_we = cmd.shift_wr | cmd.write_new;
  assign wdata  = cmd.write_new ? value_r : rdata;

  sst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r[IDX_W-1:0]),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    if (cmd.load) begin
      lo_nxt    = '0;
      hi_nxt    = count_r;
      found_nxt = 1'b0;
    end
    if (cmd.srch_upd) begin
      if (ent_lt) begin
        lo_nxt = mid + CNT_W'(1);
      end else begin
        hi_nxt = mid;
      end
      if (ent_eq) begin
        found_nxt = 1'b1;
      end
    end
    // shift pointer starts at the end for insert, at the hit for remove
    if (cmd.ptr_init) begin
      ptr_nxt = is_ins ? count_r : lo_r;
    end
    if (cmd.shift_wr) begin
      ptr_nxt = is_ins ? ptr_dec : ptr_inc;
    end
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    found_r <= found_nxt;
    ptr_r   <= ptr_nxt;
    if (cmd.res_load) begin
      success_r <= cmd.res_success;
      full_r    <= cmd.res_full;
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.found       = found_r;
    stat.full        = (count_r == CNT_W'(CAPACITY));
    stat.search_done = (lo_r >= hi_r);
    stat.shift_done  = is_ins ? (ptr_r == lo_r) : (ptr_inc == count_r);
  end

  assign out_success  = success_r;
  assign out_full_res = full_r;

endmodule

// ===== src/sst_ctrl.sv =====
`timescale 1ns / 1ps
module sst_ctrl
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sst_stat_t stat,
  output sst_cmd_t  cmd
);

  sst_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ins_ok, rem_ok;

  assign ins_ok = (stat.op == OP_INSERT) && !stat.found && !stat.full;
  assign rem_ok = (stat.op == OP_REMOVE) && stat.found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat.search_done) begin
          cmd.ptr_init = 1'b1;
          state_nxt    = (ins_ok || rem_ok) ? ST_SHIFT_RD : ST_FINISH;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = ST_SEARCH;
      end
      ST_SHIFT_RD: begin
        if (stat.shift_done) begin
          cmd.write_new = (stat.op == OP_INSERT);
          state_nxt     = ST_FINISH;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = ST_SHIFT_RD;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load    = 1'b1;
          cmd.res_success = ins_ok || rem_ok || ((stat.op == OP_QUERY) && stat.found);
          cmd.res_full    = (stat.op == OP_INSERT) && !stat.found && stat.full;
          cmd.cnt_inc     = ins_ok;
          cmd.cnt_dec     = rem_ok;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/sorted_set_table_core.sv =====
`timescale 1ns / 1ps
// sorted set of distinct signed 64-bit keys held in ascending order
// input channel: in_op (insert, remove, membership query) and in_value,
// taken on in_valid & in_ready; one result per request on the output
// channel: out_success and out_full_res, taken on out_valid & out_ready
// insert of a key already present fails; insert of a new key into a full
// table fails and raises out_full_res; remove of an absent key fails
// a request is processed alone: binary search over the table ram, with one
// read and one write port, needs at most ceil(log2(n+1)) probes (n entries)
// a successful insert then moves every entry above the slot up by one and
// a successful remove moves every entry above it down by one, one entry
// at a time, read and then written through the ram's two ports
// each request runs through its search and, after a successful insert or
// remove, its move before the next request is taken; output is
// one register, so a stalled receiver holds the result while the next
// request already runs, and only the hand-off of that next result waits
// for out_ready
// reset empties the table at once: only the count is cleared
module sorted_set_table_core
  import sst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_success,
  output logic                     out_full_res
);

  sst_cmd_t  cmd;
  sst_stat_t stat;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sst_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_op),
    .in_value     (in_value),
    .stat         (stat),
    .out_success  (out_success),
    .out_full_res (out_full_res)
  );

endmodule
